FILE: rtl/rlf_pkg.sv
package rlf_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 24;
    localparam int TIME_W  = 16;
    localparam int PROD_W  = SPEED_W + TIME_W;
    localparam int FRAC_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM  = 2'd1;
    localparam logic [OP_W-1:0] OP_SNAP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_BOTTOM = 3'd6;

    // Border reset values
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

    // Item after the step multiply, ready for the position update
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] lock_x;
        logic signed [POS_W-1:0] lock_y;
        logic [POS_W-1:0]        step;
    } step_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] bottom;
    } border_t;

    typedef struct packed {
        logic signed [POS_W-1:0] view_x;
        logic signed [POS_W-1:0] view_y;
        logic                    x_is_locked;
        logic                    y_is_locked;
    } view_t;

endpackage

FILE: rtl/rlf_cfg_if.sv
interface rlf_cfg_if import rlf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rlf_cmd_if.sv
interface rlf_cmd_if import rlf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] lock_x;
    logic signed [POS_W-1:0] lock_y;
    logic                    on_ground;
    logic                    on_spring;
    logic [TIME_W-1:0]       frame_time;

    modport source (
        output valid, output opcode, output target_x, output target_y,
        output lock_x, output lock_y, output on_ground, output on_spring,
        output frame_time, input ready
    );
    modport sink (
        input valid, input opcode, input target_x, input target_y,
        input lock_x, input lock_y, input on_ground, input on_spring,
        input frame_time, output ready
    );
endinterface

FILE: rtl/rlf_view_if.sv
interface rlf_view_if import rlf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] view_x;
    logic signed [POS_W-1:0] view_y;
    logic                    x_is_locked;
    logic                    y_is_locked;

    modport source (
        output valid, output view_x, output view_y, output x_is_locked,
        output y_is_locked, input ready
    );
    modport sink (
        input valid, input view_x, input view_y, input x_is_locked,
        input y_is_locked, output ready
    );
endinterface

FILE: rtl/rlf_track.sv
module rlf_track import rlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       update,
    input  step_item_t item,
    input  border_t    border,
    output view_t      state
);

    // Lock window: 256.0 in Q23.8, and its square
    localparam logic [POS_W:0]     LOCK_RADIUS_RAW = (POS_W+1)'(256 << FRAC_W);
    localparam int                 SQ_W            = 2 * (POS_W + 1) + 1;
    localparam logic [SQ_W-1:0]    LOCK_RADIUS_SQ  = SQ_W'(LOCK_RADIUS_RAW) * SQ_W'(LOCK_RADIUS_RAW);
    localparam int                 NEAR_W          = 17;

    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;
    logic signed [POS_W-1:0] lock_x_reg, lock_x_next;
    logic signed [POS_W-1:0] lock_y_reg, lock_y_next;
    logic armed_reg, armed_next;
    logic x_cap_reg, x_cap_next;
    logic y_cap_reg, y_cap_next;

    logic signed [POS_W-1:0] ax, ay, cx, cy, kx, ky;
    logic signed [POS_W:0]   dx, dy;
    logic [POS_W:0]          adx, ady;
    logic [2*NEAR_W-1:0]     sqx, sqy;
    logic [2*NEAR_W:0]       sq_sum;
    logic                    near, y_hit, x_hit, y_cap_tick;

    // Move cur toward need by step without passing it
    function automatic logic signed [POS_W-1:0] approach(
        input logic signed [POS_W-1:0] cur,
        input logic signed [POS_W-1:0] need,
        input logic [POS_W-1:0]        step
    );
        logic signed [POS_W+1:0] c;
        logic signed [POS_W+1:0] n;
        logic signed [POS_W+1:0] s;
        c = {{2{cur[POS_W-1]}}, cur};
        n = {{2{need[POS_W-1]}}, need};
        s = {2'b00, step};
        if (cur < need)
        begin
            c = c + s;
            if (c > n)
            begin
                c = n;
            end
        end
        else
        begin
            c = c - s;
            if (c < n)
            begin
                c = n;
            end
        end
        return c[POS_W-1:0];
    endfunction

    // Sign of (a - l) differs from sign of (b - l)
    function automatic logic crossed(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b,
        input logic signed [POS_W-1:0] l
    );
        return ((a > l) != (b > l)) || ((a < l) != (b < l));
    endfunction

    // Apply the upper bound after the lower one, so an inverted box yields max
    function automatic logic signed [POS_W-1:0] clampv(
        input logic signed [POS_W-1:0] v,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi
    );
        logic signed [POS_W-1:0] r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Tick path: approach, lock capture, clamp
    always_comb
    begin
        ax = x_cap_reg ? pos_x_reg : approach(pos_x_reg, item.target_x, item.step);
        ay = y_cap_reg ? pos_y_reg : approach(pos_y_reg, item.target_y, item.step);

        dx  = {ax[POS_W-1], ax} - {lock_x_reg[POS_W-1], lock_x_reg};
        dy  = {ay[POS_W-1], ay} - {lock_y_reg[POS_W-1], lock_y_reg};
        adx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
        ady = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
        sqx = adx[NEAR_W-1:0] * adx[NEAR_W-1:0];
        sqy = ady[NEAR_W-1:0] * ady[NEAR_W-1:0];
        sq_sum = {1'b0, sqx} + {1'b0, sqy};
        near = (adx <= LOCK_RADIUS_RAW) && (ady <= LOCK_RADIUS_RAW)
               && (SQ_W'(sq_sum) <= LOCK_RADIUS_SQ);

        y_hit = armed_reg && !y_cap_reg && near && crossed(pos_y_reg, ay, lock_y_reg);
        ky = y_hit ? lock_y_reg : ay;
        y_cap_tick = y_cap_reg || y_hit;

        x_hit = armed_reg && y_cap_tick && !x_cap_reg
                && crossed(pos_x_reg, ax, lock_x_reg);
        kx = x_hit ? lock_x_reg : ax;

        cx = clampv(kx, border.left, border.right);
        cy = clampv(ky, border.top, border.bottom);
    end

    // Select the update by opcode
    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        lock_x_next = lock_x_reg;
        lock_y_next = lock_y_reg;
        armed_next  = armed_reg;
        x_cap_next  = x_cap_reg;
        y_cap_next  = y_cap_reg;
        unique case (item.opcode)
            OP_TICK:
            begin
                pos_x_next = cx;
                pos_y_next = cy;
                x_cap_next = x_cap_reg || x_hit;
                y_cap_next = y_cap_tick;
            end
            OP_ARM:
            begin
                lock_x_next = item.lock_x;
                lock_y_next = item.lock_y;
                armed_next  = 1'b1;
                x_cap_next  = 1'b0;
                y_cap_next  = 1'b0;
            end
            OP_SNAP:
            begin
                pos_x_next = item.target_x;
                pos_y_next = item.target_y;
            end
            default:
            begin
            end
        endcase
    end

    // Hold state unless an item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            lock_x_reg <= '0;
            lock_y_reg <= '0;
            armed_reg  <= 1'b0;
            x_cap_reg  <= 1'b0;
            y_cap_reg  <= 1'b0;
        end
        else if (update)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            lock_x_reg <= lock_x_next;
            lock_y_reg <= lock_y_next;
            armed_reg  <= armed_next;
            x_cap_reg  <= x_cap_next;
            y_cap_reg  <= y_cap_next;
        end
    end

    assign state.view_x      = pos_x_reg;
    assign state.view_y      = pos_y_reg;
    assign state.x_is_locked = x_cap_reg;
    assign state.y_is_locked = y_cap_reg;

endmodule

FILE: rtl/rate_limited_follow_with_lock.sv
// A result comes from the position state after the input and step registers.
// Throughput: one item per cycle while the view receiver is ready; the position
// update (approach, lock distance squares, clamp) closes ahead of the next item.
// Reset clears position, lock point and lock flags, zeroes the speeds and
// opens the border box to the full range. Configuration is always ready.
module rate_limited_follow_with_lock import rlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rlf_cfg_if.sink    cfg,
    rlf_cmd_if.sink    cmd,
    rlf_view_if.source view
);

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] lock_x;
        logic signed [POS_W-1:0] lock_y;
        logic                    on_ground;
        logic                    on_spring;
        logic [TIME_W-1:0]       frame_time;
    } cmd_item_t;

    logic [SPEED_W-1:0] air_speed_reg, ground_speed_reg, spring_speed_reg;
    border_t            border_reg;

    logic       s1_valid_reg, s2_valid_reg, out_valid_reg;
    cmd_item_t  s1_item_reg;
    step_item_t s2_item_reg, s2_item_next;
    logic       adv_out, adv_s2, adv_s1;
    logic [SPEED_W-1:0] speed;
    logic [PROD_W-1:0]  product;
    view_t      state;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_speed_reg     <= '0;
            ground_speed_reg  <= '0;
            spring_speed_reg  <= '0;
            border_reg.left   <= POS_MIN;
            border_reg.right  <= POS_MAX;
            border_reg.top    <= POS_MIN;
            border_reg.bottom <= POS_MAX;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_AIR_SPEED:     air_speed_reg     <= cfg.data[SPEED_W-1:0];
                CFG_GROUND_SPEED:  ground_speed_reg  <= cfg.data[SPEED_W-1:0];
                CFG_SPRING_SPEED:  spring_speed_reg  <= cfg.data[SPEED_W-1:0];
                CFG_BORDER_LEFT:   border_reg.left   <= cfg.data[POS_W-1:0];
                CFG_BORDER_RIGHT:  border_reg.right  <= cfg.data[POS_W-1:0];
                CFG_BORDER_TOP:    border_reg.top    <= cfg.data[POS_W-1:0];
                CFG_BORDER_BOTTOM: border_reg.bottom <= cfg.data[POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage flow: each stage advances when empty or when the next one moves
    assign adv_out   = !out_valid_reg || view.ready;
    assign adv_s2    = !s2_valid_reg || adv_out;
    assign adv_s1    = !s1_valid_reg || adv_s2;
    assign cmd.ready = adv_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (adv_s1 && cmd.valid)
        begin
            s1_item_reg.opcode     <= cmd.opcode;
            s1_item_reg.target_x   <= cmd.target_x;
            s1_item_reg.target_y   <= cmd.target_y;
            s1_item_reg.lock_x     <= cmd.lock_x;
            s1_item_reg.lock_y     <= cmd.lock_y;
            s1_item_reg.on_ground  <= cmd.on_ground;
            s1_item_reg.on_spring  <= cmd.on_spring;
            s1_item_reg.frame_time <= cmd.frame_time;
        end
    end

    // Step size: speed times frame time, back to Q23.8
    always_comb
    begin
        speed = air_speed_reg;
        if (s1_item_reg.on_ground)
        begin
            speed = ground_speed_reg;
        end
        if (s1_item_reg.on_spring)
        begin
            speed = spring_speed_reg;
        end
        product = PROD_W'(speed) * PROD_W'(s1_item_reg.frame_time);

        s2_item_next.opcode   = s1_item_reg.opcode;
        s2_item_next.target_x = s1_item_reg.target_x;
        s2_item_next.target_y = s1_item_reg.target_y;
        s2_item_next.lock_x   = s1_item_reg.lock_x;
        s2_item_next.lock_y   = s1_item_reg.lock_y;
        s2_item_next.step     = product[FRAC_W +: POS_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2 && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    // Position state doubles as the result register
    rlf_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (s2_valid_reg && adv_out),
        .item   (s2_item_reg),
        .border (border_reg),
        .state  (state)
    );

    assign view.valid       = out_valid_reg;
    assign view.view_x      = state.view_x;
    assign view.view_y      = state.view_y;
    assign view.x_is_locked = state.x_is_locked;
    assign view.y_is_locked = state.y_is_locked;

endmodule

FILE: dv/tb_rate_limited_follow_with_lock.sv
`timescale 1ns / 100ps

module tb_rate_limited_follow_with_lock;
    import rlf_pkg::*;

    // Unused opcode: the block only reports its state
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PHASES      = 8;
    // 256.0 units in Q23.8
    localparam longint LOCK_REACH  = 64'sd65536;

    typedef struct {
        logic [OP_W-1:0]         opcode;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] lock_x;
        logic signed [POS_W-1:0] lock_y;
        logic                    on_ground;
        logic                    on_spring;
        logic [TIME_W-1:0]       frame_time;
    } track_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rlf_cfg_if  cfg ();
    rlf_cmd_if  cmd ();
    rlf_view_if view ();

    rate_limited_follow_with_lock dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .view  (view)
    );

    always #1 clk = ~clk;

    // Tracker copy: configuration
    logic [SPEED_W-1:0]      air_spd;
    logic [SPEED_W-1:0]      ground_spd;
    logic [SPEED_W-1:0]      spring_spd;
    border_t                 box;
    // Tracker copy: position and lock state
    logic signed [POS_W-1:0] cam_x;
    logic signed [POS_W-1:0] cam_y;
    logic signed [POS_W-1:0] anchor_x;
    logic signed [POS_W-1:0] anchor_y;
    logic                    anchor_armed;
    logic                    x_held;
    logic                    y_held;

    view_t pending_views[$];

    int cmds_sent     = 0;
    int views_checked = 0;
    int regs_written  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int hold_cycles   = 0;
    int y_captures    = 0;
    int x_captures    = 0;
    bit src_idle      = 1'b1;
    bit sink_idle     = 1'b1;

    function automatic void reset_tracker();
        air_spd      = '0;
        ground_spd   = '0;
        spring_spd   = '0;
        box.left     = POS_MIN;
        box.right    = POS_MAX;
        box.top      = POS_MIN;
        box.bottom   = POS_MAX;
        cam_x        = '0;
        cam_y        = '0;
        anchor_x     = '0;
        anchor_y     = '0;
        anchor_armed = 1'b0;
        x_held       = 1'b0;
        y_held       = 1'b0;
    endfunction

    // Step toward the goal, never past it
    function automatic logic signed [POS_W-1:0] move_toward(
        input logic signed [POS_W-1:0] cur,
        input logic signed [POS_W-1:0] goal,
        input longint                  step
    );
        longint c;
        c = cur;
        if (c < goal)
        begin
            c = c + step;
            if (c > goal)
                c = goal;
        end
        else
        begin
            c = c - step;
            if (c < goal)
                c = goal;
        end
        return c[POS_W-1:0];
    endfunction

    function automatic int sign_of(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit near_anchor();
        longint dx;
        longint dy;
        dx = longint'(cam_x) - longint'(anchor_x);
        dy = longint'(cam_y) - longint'(anchor_y);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        if (dx > LOCK_REACH || dy > LOCK_REACH)
            return 1'b0;
        return (dx * dx + dy * dy) <= LOCK_REACH * LOCK_REACH;
    endfunction

    // Apply max then min, so an inverted box yields max
    function automatic logic signed [POS_W-1:0] clamp_pos(
        input logic signed [POS_W-1:0] v,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi
    );
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    // Advance the tracker copy by one item and return the view it reports
    function automatic view_t track_step(input track_cmd_t it);
        logic [SPEED_W-1:0]      spd;
        longint                  step;
        logic signed [POS_W-1:0] prev_x;
        logic signed [POS_W-1:0] prev_y;
        view_t                   v;
        prev_x = cam_x;
        prev_y = cam_y;
        if (it.opcode == OP_TICK)
        begin
            spd  = it.on_spring ? spring_spd : (it.on_ground ? ground_spd : air_spd);
            step = (longint'(spd) * longint'(it.frame_time)) >>> FRAC_W;
            if (!x_held)
                cam_x = move_toward(cam_x, it.target_x, step);
            if (!y_held)
                cam_y = move_toward(cam_y, it.target_y, step);
            if (anchor_armed)
            begin
                // Y locks when it crosses the lock line close to the lock point
                if (!y_held && near_anchor() &&
                    sign_of(longint'(prev_y) - anchor_y) != sign_of(longint'(cam_y) - anchor_y))
                begin
                    cam_y  = anchor_y;
                    y_held = 1'b1;
                    y_captures++;
                end
                // X locks on its own crossing, only once Y is held
                if (y_held && !x_held &&
                    sign_of(longint'(prev_x) - anchor_x) != sign_of(longint'(cam_x) - anchor_x))
                begin
                    cam_x  = anchor_x;
                    x_held = 1'b1;
                    x_captures++;
                end
            end
            cam_x = clamp_pos(cam_x, box.left, box.right);
            cam_y = clamp_pos(cam_y, box.top, box.bottom);
        end
        else if (it.opcode == OP_ARM)
        begin
            anchor_x     = it.lock_x;
            anchor_y     = it.lock_y;
            anchor_armed = 1'b1;
            x_held       = 1'b0;
            y_held       = 1'b0;
        end
        else if (it.opcode == OP_SNAP)
        begin
            cam_x = it.target_x;
            cam_y = it.target_y;
        end
        v.view_x      = cam_x;
        v.view_y      = cam_y;
        v.x_is_locked = x_held;
        v.y_is_locked = y_held;
        return v;
    endfunction

    function automatic track_cmd_t make_cmd(
        input logic [OP_W-1:0] op,
        input int tx, input int ty, input int lx, input int ly,
        input bit gnd, input bit spr, input int ft
    );
        track_cmd_t it;
        it.opcode     = op;
        it.target_x   = tx;
        it.target_y   = ty;
        it.lock_x     = lx;
        it.lock_y     = ly;
        it.on_ground  = gnd;
        it.on_spring  = spr;
        it.frame_time = ft[TIME_W-1:0];
        return it;
    endfunction

    function automatic int rand_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Tick with random speed select and junk in the lock fields
    function automatic track_cmd_t random_tick(input int tx, input int ty);
        int ft;
        ft = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(16, 1024);
        return make_cmd(OP_TICK, tx, ty, $urandom, $urandom, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0, ft);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("ERROR %s: expected %0d, got %0d at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // Compare each accepted view with the oldest prediction
    always @(posedge clk)
    begin
        view_t want;
        if (rst_n && view.valid && view.ready)
        begin
            views_checked++;
            if (pending_views.size() == 0)
                report_mismatch("view with no item outstanding", 0, view.view_x);
            else
            begin
                want = pending_views.pop_front();
                if (view.view_x !== want.view_x)
                    report_mismatch("view_x", want.view_x, view.view_x);
                if (view.view_y !== want.view_y)
                    report_mismatch("view_y", want.view_y, view.view_y);
                if (view.x_is_locked !== want.x_is_locked)
                    report_mismatch("x_is_locked", want.x_is_locked, view.x_is_locked);
                if (view.y_is_locked !== want.y_is_locked)
                    report_mismatch("y_is_locked", want.y_is_locked, view.y_is_locked);
            end
        end
    end

    // Receiver: long hold-off first, else random stalls
    initial
    begin
        view.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                view.ready <= 1'b0;
                hold_cycles--;
            end
            else if (sink_idle && $urandom_range(0, 99) < 15)
                view.ready <= 1'b0;
            else
                view.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d views outstanding",
                     cycle_count, pending_views.size());
            $display("tb_rate_limited_follow_with_lock: FAIL");
            $finish;
        end
    end

    // Write one register; returns on a falling edge with the channel idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_AIR_SPEED:     air_spd    = value[SPEED_W-1:0];
            CFG_GROUND_SPEED:  ground_spd = value[SPEED_W-1:0];
            CFG_SPRING_SPEED:  spring_spd = value[SPEED_W-1:0];
            CFG_BORDER_LEFT:   box.left   = value;
            CFG_BORDER_RIGHT:  box.right  = value;
            CFG_BORDER_TOP:    box.top    = value;
            CFG_BORDER_BOTTOM: box.bottom = value;
            default: ;
        endcase
        regs_written++;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_speeds(input int air, input int gnd, input int spr);
        write_reg(CFG_AIR_SPEED, air);
        write_reg(CFG_GROUND_SPEED, gnd);
        write_reg(CFG_SPRING_SPEED, spr);
    endtask

    task automatic write_borders(input int left, input int right, input int top, input int bottom);
        write_reg(CFG_BORDER_LEFT, left);
        write_reg(CFG_BORDER_RIGHT, right);
        write_reg(CFG_BORDER_TOP, top);
        write_reg(CFG_BORDER_BOTTOM, bottom);
    endtask

    // Send one item; called on a falling edge, returns on one with valid still high
    task automatic send_cmd(input track_cmd_t it);
        if (src_idle && $urandom_range(0, 99) < 15)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= it.opcode;
        cmd.target_x   <= it.target_x;
        cmd.target_y   <= it.target_y;
        cmd.lock_x     <= it.lock_x;
        cmd.lock_y     <= it.lock_y;
        cmd.on_ground  <= it.on_ground;
        cmd.on_spring  <= it.on_spring;
        cmd.frame_time <= it.frame_time;
        do
            @(posedge clk);
        while (!cmd.ready);
        pending_views.push_back(track_step(it));
        cmds_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every view is back and the pipeline is empty
    task automatic drain_views();
        cmd.valid <= 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Change idling on a rising edge so the receiver never races the update
    task automatic set_idling(input bit src, input bit sink);
        cmd.valid <= 1'b0;
        @(posedge clk);
        src_idle  = src;
        sink_idle = sink;
        @(negedge clk);
    endtask

    // Usually snap near a lock point, then arm it and tick across it
    task automatic send_lock_pass();
        int lx;
        int ly;
        int px;
        int py;
        int tx;
        int ty;
        lx = rand_offset(2000 << 8);
        ly = rand_offset(2000 << 8);
        px = lx + rand_offset(150 << 8);
        py = ly + rand_offset(150 << 8);
        tx = 2 * lx - px + rand_offset(40 << 8);
        ty = 2 * ly - py + rand_offset(40 << 8);
        if ($urandom_range(0, 4) != 0)
            send_cmd(make_cmd(OP_SNAP, px, py, $urandom, $urandom, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom));
        send_cmd(make_cmd(OP_ARM, $urandom, $urandom, lx, ly, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom));
        repeat ($urandom_range(2, 12))
            send_cmd(random_tick(tx, ty));
    endtask

    task automatic send_random_burst(input int count);
        int goal;
        int pick;
        int tx;
        int ty;
        goal = cmds_sent + count;
        while (cmds_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_lock_pass();
            else if (pick < 85)
            begin
                tx = rand_offset(2500 << 8);
                ty = rand_offset(2500 << 8);
                repeat ($urandom_range(1, 6))
                    send_cmd(random_tick(tx, ty));
            end
            else
                send_cmd(make_cmd(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                  $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 65535)));
        end
    endtask

    // Speeds are zero after reset, so nothing moves
    task automatic test_reset_defaults();
        send_cmd(make_cmd(OP_TICK, POS_MAX, POS_MIN, 0, 0, 1'b1, 1'b0, 'hFFFF));
        send_cmd(make_cmd(OP_TICK, POS_MIN, POS_MAX, 0, 0, 1'b0, 1'b1, 'hFFFF));
        send_cmd(make_cmd(OP_NONE, POS_MAX, POS_MAX, POS_MIN, POS_MIN, 1'b1, 1'b1, 'hFFFF));
    endtask

    // Speed select, step limits and snap over the full range
    task automatic test_directed_tracking();
        drain_views();
        write_speeds(32'h0000_0100, 32'h0000_0200, 32'h00FF_FFFF);
        write_borders(POS_MIN, POS_MAX, POS_MIN, POS_MAX);
        send_cmd(make_cmd(OP_TICK, 1000 << 8, -(1000 << 8), 0, 0, 1'b0, 1'b0, 'h0100));
        send_cmd(make_cmd(OP_TICK, 1000 << 8, -(1000 << 8), 0, 0, 1'b1, 1'b0, 'hFFFF));
        send_cmd(make_cmd(OP_TICK, 1000 << 8, -(1000 << 8), 0, 0, 1'b1, 1'b1, 'h0000));
        send_cmd(make_cmd(OP_TICK, POS_MAX, POS_MIN, 0, 0, 1'b1, 1'b1, 'hFFFF));
        send_cmd(make_cmd(OP_TICK, POS_MIN, POS_MAX, 0, 0, 1'b0, 1'b0, 'hFFFF));
        send_cmd(make_cmd(OP_SNAP, POS_MIN, POS_MAX, 0, 0, 1'b0, 1'b0, 0));
        // Largest step falls just short of the full swing
        send_cmd(make_cmd(OP_TICK, POS_MAX, POS_MIN, 0, 0, 1'b0, 1'b1, 'hFFFF));
        send_cmd(make_cmd(OP_SNAP, 0, 0, 0, 0, 1'b0, 1'b0, 0));
    endtask

    // Air speed is 1.0, so the step equals frame_time in raw units
    task automatic test_lock_capture();
        // Both axes cross in one tick and lock together
        send_cmd(make_cmd(OP_ARM, 0, 0, 10 << 8, 20 << 8, 1'b0, 1'b0, 0));
        send_cmd(make_cmd(OP_TICK, 100 << 8, 100 << 8, 0, 0, 1'b0, 1'b0, 'h2000));
        send_cmd(make_cmd(OP_TICK, -(100 << 8), -(100 << 8), 0, 0, 1'b0, 1'b0, 'h2000));
        // Snap keeps the locks
        send_cmd(make_cmd(OP_SNAP, 0, 0, 0, 0, 1'b0, 1'b0, 0));
        // Rearm clears the locks; Y lands exactly on the lock line, X comes later
        send_cmd(make_cmd(OP_ARM, 0, 0, 20 << 8, 4 << 8, 1'b0, 1'b0, 0));
        send_cmd(make_cmd(OP_TICK, 100 << 8, 4 << 8, 0, 0, 1'b0, 1'b0, 'h0400));
        send_cmd(make_cmd(OP_TICK, 100 << 8, 4 << 8, 0, 0, 1'b0, 1'b0, 'h1000));
        send_cmd(make_cmd(OP_NONE, 0, 0, 0, 0, 1'b0, 1'b0, 0));
        // Crossing far from the lock point does not lock
        send_cmd(make_cmd(OP_ARM, 0, 0, 0, 32'h0100_0000, 1'b0, 1'b0, 0));
        send_cmd(make_cmd(OP_SNAP, 32'h0020_0000, 32'h00FF_FF00, 0, 0, 1'b0, 1'b0, 0));
        send_cmd(make_cmd(OP_TICK, 32'h0020_0000, 32'h0100_1000, 0, 0, 1'b0, 1'b0, 'h0400));
    endtask

    // Clamp to a small box, snap past it, then an inverted box
    task automatic test_borders();
        drain_views();
        write_borders(-(100 << 8), 100 << 8, -(50 << 8), 50 << 8);
        send_cmd(make_cmd(OP_TICK, POS_MAX, POS_MIN, 0, 0, 1'b0, 1'b1, 'hFFFF));
        send_cmd(make_cmd(OP_SNAP, POS_MIN, POS_MAX, 0, 0, 1'b0, 1'b0, 0));
        send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0, 1'b0, 'h0000));
        drain_views();
        write_borders(100 << 8, -(100 << 8), 50 << 8, -(50 << 8));
        send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0, 1'b0, 'h0010));
        send_cmd(make_cmd(OP_SNAP, 0, 0, 0, 0, 1'b0, 1'b0, 0));
    endtask

    // Receiver stops for a long stretch while items keep coming
    task automatic test_backpressure();
        drain_views();
        write_borders(POS_MIN, POS_MAX, POS_MIN, POS_MAX);
        set_idling(1'b0, 1'b0);
        cmd.valid <= 1'b0;
        @(posedge clk);
        hold_cycles = 100;
        @(negedge clk);
        send_random_burst(40);
        set_idling(1'b1, 1'b1);
    endtask

    // Phases of random items, each under its own register setting
    task automatic test_random_phases(input int total);
        int span;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_views();
            case (p)
                2:       write_speeds(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
                3:       write_speeds(0, 0, $urandom_range(32'h40, 32'h1000));
                4:       write_speeds($urandom, $urandom, $urandom);
                default: write_speeds($urandom_range(32'h40, 32'h1000),
                                      $urandom_range(32'h40, 32'h1000),
                                      $urandom_range(32'h40, 32'h1000));
            endcase
            span = $urandom_range(500, 3000) << 8;
            case (p)
                1, 7:    write_borders(-span, span, -($urandom_range(500, 3000) << 8),
                                       $urandom_range(500, 3000) << 8);
                2, 4:    write_borders($urandom, $urandom, $urandom, $urandom);
                3:       write_borders($urandom_range(1, 1000) << 8, -span,
                                       $urandom_range(1, 1000) << 8,
                                       -($urandom_range(1, 1000) << 8));
                default: write_borders(POS_MIN, POS_MAX, POS_MIN, POS_MAX);
            endcase
            // One phase runs with no idling on either side
            set_idling(p != 5, p != 5);
            send_random_burst(total / PHASES);
        end
    endtask

    initial
    begin
        cfg.valid      = 1'b0;
        cfg.index      = CFG_AIR_SPEED;
        cfg.data       = '0;
        cmd.valid      = 1'b0;
        cmd.opcode     = OP_TICK;
        cmd.target_x   = '0;
        cmd.target_y   = '0;
        cmd.lock_x     = '0;
        cmd.lock_y     = '0;
        cmd.on_ground  = 1'b0;
        cmd.on_spring  = 1'b0;
        cmd.frame_time = '0;
        reset_tracker();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_tracking();
        test_lock_capture();
        test_borders();
        test_backpressure();
        test_random_phases(1160);

        drain_views();
        repeat (10) @(negedge clk);
        $display("run covered %0d items and %0d views over %0d random phases, %0d register writes",
                 cmds_sent, views_checked, PHASES, regs_written);
        $display("lock captures predicted: y %0d, x %0d; mismatches %0d",
                 y_captures, x_captures, mismatches);
        if (mismatches == 0)
            $display("tb_rate_limited_follow_with_lock: PASS");
        else
            $display("tb_rate_limited_follow_with_lock: FAIL");
        $finish;
    end

endmodule
